[hw/rtl/arxf_pkg.sv]
// Package for the ARX Feistel cipher: pipeline word type, constants, round and key-schedule functions.
`default_nettype none
package arxf_pkg;

	// Schedule mixing constant
	localparam logic [31:0] MIX_CONST = 32'h5A827999;

	// Word carried along the round pipeline
	typedef struct packed {
		logic        cmd;
		logic [63:0] blk;
	} arxf_word_t;

	// Command codes
	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	// Configuration register indexes
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	function automatic logic [7:0] rol8(input logic [7:0] v, input logic [2:0] s);
		logic [15:0] t;
		t = {v, v} << s;
		return t[15:8];
	endfunction

	function automatic logic [7:0] ror8(input logic [7:0] v, input logic [2:0] s);
		logic [15:0] t;
		t = {v, v} >> s;
		return t[7:0];
	endfunction

	// One forward round; odd rounds touch bytes 4-7
	function automatic logic [63:0] round_fwd(input logic [63:0] b, input logic [31:0] k,
		input logic odd);
		logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7;
		logic [7:0] k0, k1, k2, k3;
		b0 = b[7:0];   b1 = b[15:8];  b2 = b[23:16]; b3 = b[31:24];
		b4 = b[39:32]; b5 = b[47:40]; b6 = b[55:48]; b7 = b[63:56];
		k0 = k[7:0];   k1 = k[15:8];  k2 = k[23:16]; k3 = k[31:24];
		if (!odd) begin
			b0 = rol8(b0 ^ k0, 3'd1) + b1;
			b1 = rol8(b1 ^ k1, 3'd3) ^ b2;
			b2 = rol8(b2 + k2, 3'd4) ^ b3;
			b3 = rol8(b3 ^ k3, 3'd5) + b0;
		end else begin
			b4 = rol8(b4 + k0, 3'd2) ^ b5;
			b5 = rol8(b5 ^ k1, 3'd4) + b6;
			b6 = rol8(b6 + k2, 3'd5) ^ b7;
			b7 = rol8(b7 ^ k3, 3'd6) + b4;
		end
		return {b7, b6, b5, b4, b3, b2, b1, b0};
	endfunction

	// Inverse of round_fwd
	function automatic logic [63:0] round_inv(input logic [63:0] b, input logic [31:0] k,
		input logic odd);
		logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7;
		logic [7:0] k0, k1, k2, k3;
		b0 = b[7:0];   b1 = b[15:8];  b2 = b[23:16]; b3 = b[31:24];
		b4 = b[39:32]; b5 = b[47:40]; b6 = b[55:48]; b7 = b[63:56];
		k0 = k[7:0];   k1 = k[15:8];  k2 = k[23:16]; k3 = k[31:24];
		if (!odd) begin
			b3 = ror8(b3 - b0, 3'd5) ^ k3;
			b2 = ror8(b2 ^ b3, 3'd4) - k2;
			b1 = ror8(b1 ^ b2, 3'd3) ^ k1;
			b0 = ror8(b0 - b1, 3'd1) ^ k0;
		end else begin
			b7 = ror8(b7 - b4, 3'd6) ^ k3;
			b6 = ror8(b6 ^ b7, 3'd5) - k2;
			b5 = ror8(b5 - b6, 3'd4) ^ k1;
			b4 = ror8(b4 ^ b5, 3'd2) - k0;
		end
		return {b7, b6, b5, b4, b3, b2, b1, b0};
	endfunction

	// One key-schedule step: rotate bytes, mix constant and round number
	function automatic logic [127:0] sched_step(input logic [127:0] w, input int s,
		input logic [7:0] r);
		logic [127:0] t;
		t = {w[7:0], w[127:8]};
		t[8*s +: 8] = t[8*s +: 8] ^ MIX_CONST[8*s +: 8];
		t[8*(s+7) +: 8] = t[8*(s+7) +: 8] ^ r;
		return t;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/arx_feistel_64bit_block_cipher.sv]
// Top level of the 64-bit ARX Feistel block cipher: whitening, round cells, key schedule.
//
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall  command, block_in
//  out      out  out_valid/out_stall  block_out
//  cfg      in   cfg_we               cfg_index, cfg_wdata
//
// One word per cycle unless busy or out_stall holds it back, through an input register,
// one cell per round and an output register. A stalled stage only holds back the
// stages behind it that are full. After reset or a key write, the schedule sequencer
// writes one round row per cycle, then the final whitening bytes, in_stall held high.
`default_nettype none
module arx_feistel_64bit_block_cipher import arxf_pkg::*; #(
	parameter int ROUNDS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [63:0] block_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      block_out,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_wdata
);
	localparam int NSK = 4*ROUNDS + 8;

	logic [63:0] key_low_q, key_high_q;
	logic [63:0] key_low_nxt, key_high_nxt;
	logic        busy;
	logic [8*NSK-1:0] sk;
	logic [63:0] wh_first, wh_last;

	// Key registers
	assign key_low_nxt  = (cfg_we && cfg_index == REG_KEY_LOW)  ? cfg_wdata : key_low_q;
	assign key_high_nxt = (cfg_we && cfg_index == REG_KEY_HIGH) ? cfg_wdata : key_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else begin
			key_low_q  <= key_low_nxt;
			key_high_q <= key_high_nxt;
		end
	end

	arxf_sched #(.ROUNDS(ROUNDS)) u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cfg_we),
		.key    ({key_high_nxt, key_low_nxt}),
		.busy   (busy),
		.sk     (sk)
	);

	assign wh_first = sk[63:0];
	assign wh_last  = sk[8*4*ROUNDS +: 64];

	// Pipeline: stage 0 = whitened input, then one cell per round
	logic       v   [ROUNDS+1];
	arxf_word_t d   [ROUNDS+1];
	logic       rdy [ROUNDS+2];
	logic       v0_q;
	arxf_word_t d0_q;
	logic       acc;

	assign rdy[0]   = !v0_q || rdy[1];
	assign acc      = in_valid && !busy;
	assign in_stall = busy || !rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
		end else if (rdy[0]) begin
			v0_q <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && acc) begin
			d0_q.cmd <= command;
			d0_q.blk <= block_in ^ ((command == CMD_DEC) ? wh_last : wh_first);
		end
	end

	assign v[0] = v0_q;
	assign d[0] = d0_q;

	for (genvar k = 0; k < ROUNDS; k++) begin : g_cell
		arxf_cell #(
			.ENC_ODD ((k % 2) == 1),
			.DEC_ODD (((ROUNDS-1-k) % 2) == 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.v_in     (v[k]),
			.d_in     (d[k]),
			.rdy_next (rdy[k+2]),
			.key_enc  (sk[8*(8+4*k) +: 32]),
			.key_dec  (sk[8*(8+4*(ROUNDS-1-k)) +: 32]),
			.rdy_prev (rdy[k+1]),
			.v_out    (v[k+1]),
			.d_out    (d[k+1])
		);
	end

	// Output register with final whitening
	logic        out_v_q;
	logic [63:0] out_d_q;

	assign rdy[ROUNDS+1] = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy[ROUNDS+1]) begin
			out_v_q <= v[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[ROUNDS+1] && v[ROUNDS]) begin
			out_d_q <= d[ROUNDS].blk ^
				((d[ROUNDS].cmd == CMD_DEC) ? wh_first : wh_last);
		end
	end

	assign out_valid = out_v_q;
	assign block_out = out_d_q;

endmodule
`default_nettype wire

[hw/rtl/arxf_sched.sv]
// Key schedule sequencer and subkey register file.
`default_nettype none
module arxf_sched import arxf_pkg::*; #(
	parameter int ROUNDS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic [127:0]              key,
	output logic                           busy,
	output logic [8*(4*ROUNDS+8)-1:0]      sk
);
	localparam int NSK = 4*ROUNDS + 8;
	localparam int CW  = $clog2(ROUNDS + 1);

	logic [127:0]  wk_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [7:0]    store_q [NSK];
	logic [127:0]  w [5];
	logic [7:0]    kb [4];

	// Four chained schedule steps per cycle
	always_comb begin
		w[0] = wk_q;
		for (int s = 0; s < 4; s++) begin
			w[s+1] = sched_step(w[s], s, 8'(cnt_q));
			kb[s]  = w[s+1][16*s +: 8] ^ w[s+1][16*s+8 +: 8];
		end
	end

	// Sequencer: one round row per cycle, then the final whitening bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (load) begin
			wk_q   <= key;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q == CW'(ROUNDS)) begin
				busy_q <= 1'b0;
			end else begin
				wk_q  <= w[4];
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Subkey writes
	always_ff @(posedge clk) begin
		if (busy_q && !load) begin
			for (int j = 0; j < ROUNDS; j++) begin
				if (cnt_q == CW'(j)) begin
					for (int s = 0; s < 4; s++) store_q[4*j+s] <= kb[s];
				end
			end
			if (cnt_q == CW'(ROUNDS)) begin
				for (int i = 0; i < 8; i++)
					store_q[4*ROUNDS+i] <= wk_q[8*i +: 8] ^ wk_q[8*(15-i) +: 8];
			end
		end
	end

	always_comb begin
		for (int e = 0; e < NSK; e++) sk[8*e +: 8] = store_q[e];
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

[hw/rtl/arxf_cell.sv]
// One round cell of the cipher pipeline, forward or inverse by command.
`default_nettype none
module arxf_cell import arxf_pkg::*; #(
	parameter bit ENC_ODD = 1'b0,
	parameter bit DEC_ODD = 1'b0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       v_in,
	input  wire arxf_word_t d_in,
	input  wire logic       rdy_next,
	input  wire logic [31:0] key_enc,
	input  wire logic [31:0] key_dec,
	output logic            rdy_prev,
	output logic            v_out,
	output arxf_word_t      d_out
);
	logic       v_q;
	arxf_word_t d_q;
	logic [63:0] nxt;

	assign rdy_prev = !v_q || rdy_next;

	// Round logic
	always_comb begin
		if (d_in.cmd == CMD_DEC) nxt = round_inv(d_in.blk, key_dec, DEC_ODD);
		else                     nxt = round_fwd(d_in.blk, key_enc, ENC_ODD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_prev) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_prev && v_in) begin
			d_q.cmd <= d_in.cmd;
			d_q.blk <= nxt;
		end
	end

	assign v_out = v_q;
	assign d_out = d_q;

endmodule
`default_nettype wire
